[rtl/ppc_pkg.sv]
// Shared types, constants and helpers for the single-plane polygon clipper.
package ppc_pkg;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int CW         = 32;
   localparam int DW         = 64;
   localparam int QDEPTH     = 2;
   localparam int CSR_IW     = 8;

   localparam logic [1:0] JOB_POINT = 2'd0;
   localparam logic [1:0] JOB_CROSS = 2'd1;
   localparam logic [1:0] JOB_MARK  = 2'd2;

   localparam logic [CSR_IW-1:0] REG_NORMAL_X = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] REG_NORMAL_Y = CSR_IW'(1);
   localparam logic [CSR_IW-1:0] REG_NORMAL_Z = CSR_IW'(2);
   localparam logic [CSR_IW-1:0] REG_PLANE_D  = CSR_IW'(3);

   localparam logic signed [CW-1:0] NORMAL_Z_RESET = CW'(65536);

   typedef struct packed {
      logic [1:0]             kind;
      logic                   end_flag;
      logic signed [CW-1:0]   px;
      logic signed [CW-1:0]   py;
      logic signed [CW-1:0]   pz;
      logic signed [CW-1:0]   qx;
      logic signed [CW-1:0]   qy;
      logic signed [CW-1:0]   qz;
      logic signed [DW-1:0]   dp;
      logic signed [DW-1:0]   dq;
   } job_type;

   function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
      logic signed [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      if (s[DW] != s[DW-1]) begin
         sat_add = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         sat_add = s[DW-1:0];
      end
   endfunction

endpackage

[rtl/ppc_fifo.sv]
// Short job queue between the classifying front end and the execution back end.
module ppc_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ppc_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ppc_pkg::job_type pop_job
);
   import ppc_pkg::*;

   localparam int AW = $clog2(QDEPTH);

   job_type            mem [QDEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [AW:0]        count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != (AW+1)'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QDEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QDEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/ppc_front.sv]
// Front end: plane registers, vertex distance, edge classification into jobs.
module ppc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ppc_pkg::CSR_IW-1:0]      csr_index,
   input  logic [ppc_pkg::CW-1:0]          csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [ppc_pkg::CW-1:0]   req_vert_x,
   input  logic signed [ppc_pkg::CW-1:0]   req_vert_y,
   input  logic signed [ppc_pkg::CW-1:0]   req_vert_z,
   input  logic                            req_final_vertex,
   output logic                            push_valid,
   input  logic                            push_ready,
   output ppc_pkg::job_type                push_job
);
   import ppc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIST = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam int SH = CW - COORD_BITS;

   logic [1:0]              state_ff, state_in;
   logic [2:0]              phase_ff, phase_in;
   logic [2:0]              slot_ff, slot_in;
   logic signed [CW-1:0]    nx_ff, ny_ff, nz_ff, pd_ff;
   logic signed [CW-1:0]    vx_ff, vy_ff, vz_ff;
   logic                    fin_ff;
   logic signed [DW-1:0]    prod_ff, prod_in;
   logic signed [DW-1:0]    acc_ff, acc_in;
   logic signed [CW-1:0]    fx_ff, fy_ff, fz_ff;
   logic signed [DW-1:0]    fd_ff;
   logic signed [CW-1:0]    qx_ff, qy_ff, qz_ff;
   logic signed [DW-1:0]    qd_ff;
   logic                    started_ff, emitted_ff;
   logic signed [CW-1:0]    mul_a, mul_b;
   logic signed [DW-1:0]    pd_shift;
   logic signed [CW-1:0]    efx, efy, efz;
   logic signed [DW-1:0]    efd;
   logic                    prev_in, vert_in, first_in;
   logic [4:0]              act;
   logic [4:0]              above;
   logic                    cur, accept, finish;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff <= '0;
         ny_ff <= '0;
         nz_ff <= NORMAL_Z_RESET;
         pd_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_NORMAL_X: nx_ff <= csr_wdata;
            REG_NORMAL_Y: ny_ff <= csr_wdata;
            REG_NORMAL_Z: nz_ff <= csr_wdata;
            REG_PLANE_D:  pd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // One shared signed multiplier walks the three axes.
   always_comb begin
      case (phase_ff)
         3'd0: begin
            mul_a = nx_ff;
            mul_b = vx_ff;
         end
         3'd1: begin
            mul_a = ny_ff;
            mul_b = vy_ff;
         end
         3'd2: begin
            mul_a = nz_ff;
            mul_b = vz_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign pd_shift = DW'(signed'(pd_ff)) <<< FRAC_BITS;

   always_comb begin
      prod_in = mul_a * mul_b;
      case (phase_ff)
         3'd0:    acc_in = '0;
         3'd4:    acc_in = sat_add(acc_ff, -pd_shift);
         default: acc_in = sat_add(acc_ff, prod_ff);
      endcase
   end

   // A polygon that opens on this vertex closes back onto the vertex itself.
   assign efx = started_ff ? fx_ff : vx_ff;
   assign efy = started_ff ? fy_ff : vy_ff;
   assign efz = started_ff ? fz_ff : vz_ff;
   assign efd = started_ff ? fd_ff : acc_ff;

   assign prev_in  = (qd_ff <= 0);
   assign vert_in  = (acc_ff <= 0);
   assign first_in = (efd <= 0);

   always_comb begin
      act[0] = started_ff && prev_in;
      act[1] = started_ff && (prev_in != vert_in);
      act[2] = fin_ff && vert_in;
      act[3] = fin_ff && (vert_in != first_in);
      act[4] = fin_ff && (act[3:0] == 4'd0) && !emitted_ff;
   end

   assign above  = act >> (slot_ff + 3'd1);
   assign cur    = act[slot_ff];
   assign finish = (state_ff == ST_EMIT) && (!cur || push_ready) && (slot_ff == 3'd4);

   always_comb begin
      push_job          = '0;
      push_job.end_flag = fin_ff && (above == 5'd0);
      push_job.px       = vx_ff;
      push_job.py       = vy_ff;
      push_job.pz       = vz_ff;
      push_job.qx       = efx;
      push_job.qy       = efy;
      push_job.qz       = efz;
      push_job.dp       = acc_ff;
      push_job.dq       = efd;
      case (slot_ff)
         3'd0: begin
            push_job.kind = JOB_POINT;
            push_job.px   = qx_ff;
            push_job.py   = qy_ff;
            push_job.pz   = qz_ff;
         end
         3'd1: begin
            push_job.kind = JOB_CROSS;
            push_job.px   = qx_ff;
            push_job.py   = qy_ff;
            push_job.pz   = qz_ff;
            push_job.dp   = qd_ff;
            push_job.qx   = vx_ff;
            push_job.qy   = vy_ff;
            push_job.qz   = vz_ff;
            push_job.dq   = acc_ff;
         end
         3'd2:    push_job.kind = JOB_POINT;
         3'd3:    push_job.kind = JOB_CROSS;
         default: begin
            push_job.kind = JOB_MARK;
            push_job.px   = '0;
            push_job.py   = '0;
            push_job.pz   = '0;
         end
      endcase
   end

   assign push_valid = (state_ff == ST_EMIT) && cur;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      slot_in  = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIST;
               phase_in = '0;
            end
         end
         ST_DIST: begin
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd4) begin
               state_in = ST_EMIT;
               slot_in  = '0;
            end
         end
         ST_EMIT: begin
            if (!cur || push_ready) begin
               slot_in = slot_ff + 3'd1;
               if (slot_ff == 3'd4) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= '0;
         slot_ff    <= '0;
         started_ff <= 1'b0;
         emitted_ff <= 1'b0;
         fx_ff      <= '0;
         fy_ff      <= '0;
         fz_ff      <= '0;
         fd_ff      <= '0;
         qx_ff      <= '0;
         qy_ff      <= '0;
         qz_ff      <= '0;
         qd_ff      <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         if (finish) begin
            if (!started_ff) begin
               fx_ff <= vx_ff;
               fy_ff <= vy_ff;
               fz_ff <= vz_ff;
               fd_ff <= acc_ff;
            end
            qx_ff      <= vx_ff;
            qy_ff      <= vy_ff;
            qz_ff      <= vz_ff;
            qd_ff      <= acc_ff;
            started_ff <= !fin_ff;
            emitted_ff <= !fin_ff && started_ff && (emitted_ff || act[0] || act[1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vx_ff  <= CW'(signed'(req_vert_x <<< SH) >>> SH);
         vy_ff  <= CW'(signed'(req_vert_y <<< SH) >>> SH);
         vz_ff  <= CW'(signed'(req_vert_z <<< SH) >>> SH);
         fin_ff <= req_final_vertex;
      end
      if (state_ff == ST_DIST) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

[rtl/ppc_back.sv]
// Back end: executes queued jobs, computing edge crossings with a serial divider.
module ppc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  ppc_pkg::job_type                pop_job,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [ppc_pkg::CW-1:0]   rsp_out_x,
   output logic signed [ppc_pkg::CW-1:0]   rsp_out_y,
   output logic signed [ppc_pkg::CW-1:0]   rsp_out_z,
   output logic                            rsp_has_vertex,
   output logic                            rsp_polygon_end
);
   import ppc_pkg::*;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_DIV  = 2'd1;
   localparam logic [1:0] B_MUL  = 2'd2;
   localparam logic [1:0] B_OUT  = 2'd3;
   localparam int TW = CW + 1;

   logic [1:0]              state_ff;
   logic [4:0]              bit_ff;
   logic [1:0]              axis_ff;
   job_type                 job_ff;
   logic [DW-1:0]           den_ff, rem_ff;
   logic [TW-1:0]           t_ff;
   logic [2*TW-1:0]         prod_ff;
   logic signed [CW-1:0]    res_ff [3];
   logic                    has_ff;
   logic                    out_valid_ff;
   logic [DW-1:0]           mag_a, mag_b, ha, hb, den_c;
   logic [DW-1:0]           dr;
   logic signed [CW-1:0]    pc [3];
   logic signed [CW-1:0]    qc [3];
   logic signed [CW:0]      delta [3];
   logic [TW-1:0]           dmag [3];
   logic [1:0]              ridx;
   logic [TW:0]             off;
   logic                    out_free;

   assign pc[0] = job_ff.px;
   assign pc[1] = job_ff.py;
   assign pc[2] = job_ff.pz;
   assign qc[0] = job_ff.qx;
   assign qc[1] = job_ff.qy;
   assign qc[2] = job_ff.qz;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         delta[i] = {qc[i][CW-1], qc[i]} - {pc[i][CW-1], pc[i]};
         dmag[i]  = delta[i][CW] ? TW'(-delta[i]) : TW'(delta[i]);
      end
   end

   assign mag_a = pop_job.dp[DW-1] ? DW'(-pop_job.dp) : DW'(pop_job.dp);
   assign mag_b = pop_job.dq[DW-1] ? DW'(-pop_job.dq) : DW'(pop_job.dq);
   assign ha    = (mag_a[DW-1] || mag_b[DW-1]) ? (mag_a >> 1) : mag_a;
   assign hb    = (mag_a[DW-1] || mag_b[DW-1]) ? (mag_b >> 1) : mag_b;
   assign den_c = ha + hb;
   assign dr    = den_ff - rem_ff;

   // The product carries 32 fraction bits; round half up before dropping them.
   assign ridx = axis_ff - 2'd1;
   assign off  = (TW+1)'((prod_ff + (2*TW)'(64'h8000_0000)) >> CW);

   assign out_free  = !out_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == B_IDLE);
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         bit_ff       <= '0;
         axis_ff      <= '0;
      end else begin
         if ((state_ff == B_OUT) && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  case (pop_job.kind)
                     JOB_CROSS: begin
                        if (ha >= den_c) begin
                           state_ff <= B_MUL;
                           axis_ff  <= '0;
                        end else begin
                           state_ff <= B_DIV;
                           bit_ff   <= '0;
                        end
                     end
                     default: state_ff <= B_OUT;
                  endcase
               end
            end
            B_DIV: begin
               bit_ff <= bit_ff + 5'd1;
               if (bit_ff == 5'd31) begin
                  state_ff <= B_MUL;
                  axis_ff  <= '0;
               end
            end
            B_MUL: begin
               axis_ff <= axis_ff + 2'd1;
               if (axis_ff == 2'd3) begin
                  state_ff <= B_OUT;
               end
            end
            B_OUT: begin
               if (out_free) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               job_ff <= pop_job;
               has_ff <= (pop_job.kind != JOB_MARK);
               res_ff[0] <= pop_job.px;
               res_ff[1] <= pop_job.py;
               res_ff[2] <= pop_job.pz;
               den_ff <= den_c;
               rem_ff <= ha;
               t_ff   <= (ha >= den_c) ? {1'b1, {CW{1'b0}}} : '0;
            end
         end
         B_DIV: begin
            if (rem_ff >= dr) begin
               rem_ff <= rem_ff - dr;
               t_ff   <= {t_ff[TW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_ff + rem_ff;
               t_ff   <= {t_ff[TW-2:0], 1'b0};
            end
         end
         B_MUL: begin
            if (axis_ff != 2'd3) begin
               prod_ff <= dmag[axis_ff] * t_ff;
            end
            if (axis_ff != 2'd0) begin
               res_ff[ridx] <= delta[ridx][CW] ? pc[ridx] - CW'(off)
                                               : pc[ridx] + CW'(off);
            end
         end
         B_OUT: begin
            if (out_free) begin
               rsp_out_x       <= res_ff[0];
               rsp_out_y       <= res_ff[1];
               rsp_out_z       <= res_ff[2];
               rsp_has_vertex  <= has_ff;
               rsp_polygon_end <= job_ff.end_flag;
            end
         end
         default: ;
      endcase
   end

endmodule

[rtl/polygon_plane_clip_core.sv]
// Top level of the single-plane polygon clipper.
// Vertices stream in one transaction each; the final vertex closes the polygon.
// The front end takes a new vertex only when idle: distance work on one shared
// 32x32 multiplier, then an emit pass that queues up to three output jobs. The
// back end moves a plain vertex taken from the queue straight into its result
// register; an edge crossing first runs the one-bit-per-cycle 32-step divider,
// skipped when the ratio saturates at one, then a multiply-and-round pass over
// the three axes. A two-entry job queue lets the two ends stall independently,
// and the result register lets a new job start while a result waits
// to be taken.
module polygon_plane_clip_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ppc_pkg::CSR_IW-1:0]      csr_index,
   input  logic [ppc_pkg::CW-1:0]          csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [ppc_pkg::CW-1:0]   req_vert_x,
   input  logic signed [ppc_pkg::CW-1:0]   req_vert_y,
   input  logic signed [ppc_pkg::CW-1:0]   req_vert_z,
   input  logic                            req_final_vertex,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [ppc_pkg::CW-1:0]   rsp_out_x,
   output logic signed [ppc_pkg::CW-1:0]   rsp_out_y,
   output logic signed [ppc_pkg::CW-1:0]   rsp_out_z,
   output logic                            rsp_has_vertex,
   output logic                            rsp_polygon_end
);
   import ppc_pkg::*;

   logic    push_valid, push_ready, pop_valid, pop_ready;
   job_type push_job, pop_job;

   ppc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_vert_x       (req_vert_x),
      .req_vert_y       (req_vert_y),
      .req_vert_z       (req_vert_z),
      .req_final_vertex (req_final_vertex),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_job         (push_job)
   );

   ppc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   ppc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_job         (pop_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_has_vertex  (rsp_has_vertex),
      .rsp_polygon_end (rsp_polygon_end)
   );

endmodule

[sim/polygon_plane_clip_core_test.sv]
// Testbench for the single-plane polygon clipper: random and directed polygons checked against a local predictor.
`timescale 1ns / 1ps

typedef struct {
   logic [31:0] x;
   logic [31:0] y;
   logic [31:0] z;
   logic        has_vertex;
   logic        polygon_end;
} clip_item_type;

class clip_scoreboard;
   clip_item_type expected_items[$];
   int errors;
   longint nx, ny, nz, pd;
   longint first_pt[3], prev_pt[3];
   longint first_dist, prev_dist;
   bit opened, emitted;

   function void clear();
      nx = 0; ny = 0; nz = 65536; pd = 0;
      opened = 0; emitted = 0;
      first_dist = 0; prev_dist = 0;
      for (int i = 0; i < 3; i++) begin
         first_pt[i] = 0; prev_pt[i] = 0;
      end
      errors = 0;
   endfunction

   function void write_reg(logic [7:0] idx, logic [31:0] val);
      longint v;
      v = longint'($signed(val));
      case (idx)
         ppc_pkg::REG_NORMAL_X: nx = v;
         ppc_pkg::REG_NORMAL_Y: ny = v;
         ppc_pkg::REG_NORMAL_Z: nz = v;
         ppc_pkg::REG_PLANE_D:  pd = v;
         default: ;
      endcase
   endfunction

   function longint sat64(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
      return s[63:0];
   endfunction

   function longint plane_dist(longint p[3]);
      longint s;
      s = sat64(nx * p[0], ny * p[1]);
      s = sat64(s, nz * p[2]);
      return sat64(s, -(pd * 65536));
   endfunction

   function void push_point(longint p[3], bit has);
      clip_item_type it;
      it.x = p[0][31:0]; it.y = p[1][31:0]; it.z = p[2][31:0];
      it.has_vertex = has; it.polygon_end = 0;
      expected_items = {expected_items, it};
   endfunction

   function void push_crossing(longint p[3], longint q[3], longint dp, longint dq);
      logic [63:0] a, b, den, t, r, mag, off;
      longint res[3], delta;
      logic [127:0] prod;
      a = dp < 0 ? -dp : dp;
      b = dq < 0 ? -dq : dq;
      if (a[63] | b[63]) begin
         a = a >> 1; b = b >> 1;
      end
      den = a + b;
      if (a >= den) t = 64'h1_0000_0000;
      else begin
         t = 0; r = a;
         for (int i = 0; i < 32; i++) begin
            t = t << 1;
            if (r >= den - r) begin
               r = r - (den - r); t[0] = 1;
            end else r = r + r;
         end
      end
      for (int i = 0; i < 3; i++) begin
         delta = q[i] - p[i];
         mag = delta < 0 ? -delta : delta;
         prod = mag * t + (64'd1 << 31);
         off = prod[95:32];
         res[i] = delta < 0 ? p[i] - longint'(off) : p[i] + longint'(off);
      end
      push_point(res, 1);
   endfunction

   // Returns how many results one edge produced.
   function int clip_edge(longint p[3], longint dp, longint q[3], longint dq);
      int n;
      n = 0;
      if (dp <= 0) begin
         push_point(p, 1); n++;
      end
      if ((dp <= 0) != (dq <= 0)) begin
         push_crossing(p, q, dp, dq); n++;
      end
      return n;
   endfunction

   function void note_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
      longint v[3], z3[3];
      longint d;
      int n;
      v[0] = longint'($signed(x)); v[1] = longint'($signed(y)); v[2] = longint'($signed(z));
      d = plane_dist(v);
      n = 0;
      if (!opened) begin
         first_pt = v; first_dist = d; opened = 1; emitted = 0;
      end else n += clip_edge(prev_pt, prev_dist, v, d);
      prev_pt = v; prev_dist = d;
      if (fin) begin
         n += clip_edge(v, d, first_pt, first_dist);
         if (n == 0 && !emitted) begin
            z3[0] = 0; z3[1] = 0; z3[2] = 0;
            push_point(z3, 0); n++;
         end
         if (n > 0) expected_items[$].polygon_end = 1;
         opened = 0; emitted = 0;
      end else if (n > 0) emitted = 1;
   endfunction

   function void check_result(clip_item_type got);
      clip_item_type want;
      if (expected_items.size() == 0) begin
         $display("%0t: unexpected result x=%h y=%h z=%h", $time, got.x, got.y, got.z);
         errors++;
         return;
      end
      want = expected_items.pop_front();
      if (got.x !== want.x) begin
         $display("%0t: out_x expected %h actual %h", $time, want.x, got.x); errors++;
      end
      if (got.y !== want.y) begin
         $display("%0t: out_y expected %h actual %h", $time, want.y, got.y); errors++;
      end
      if (got.z !== want.z) begin
         $display("%0t: out_z expected %h actual %h", $time, want.z, got.z); errors++;
      end
      if (got.has_vertex !== want.has_vertex) begin
         $display("%0t: has_vertex expected %b actual %b", $time, want.has_vertex,
                  got.has_vertex);
         errors++;
      end
      if (got.polygon_end !== want.polygon_end) begin
         $display("%0t: polygon_end expected %b actual %b", $time, want.polygon_end,
                  got.polygon_end);
         errors++;
      end
   endfunction
endclass

module polygon_plane_clip_core_test;
   import ppc_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CW-1:0] csr_wdata = '0;
   logic req_valid = 0, req_ready;
   logic signed [CW-1:0] req_vert_x = '0, req_vert_y = '0, req_vert_z = '0;
   logic req_final_vertex = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [CW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_has_vertex, rsp_polygon_end;

   clip_scoreboard clip_sb;
   int send_idle_pct = 0, recv_stall_pct = 0;
   bit recv_hold = 0;
   int quiet_cycles = 0;

   polygon_plane_clip_core dut (.*);

   always #5 clock = ~clock;

   // Result side: sample at the rising edge, drive ready at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         clip_item_type it;
         it.x = rsp_out_x; it.y = rsp_out_y; it.z = rsp_out_z;
         it.has_vertex = rsp_has_vertex; it.polygon_end = rsp_polygon_end;
         clip_sb.check_result(it);
      end
   end

   always @(negedge clock)
      rsp_ready <= !reset && !recv_hold && ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_IW-1:0] idx, logic [CW-1:0] val);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      clip_sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid <= 1; req_vert_x <= x; req_vert_y <= y; req_vert_z <= z;
      req_final_vertex <= fin;
      do @(posedge clock); while (!req_ready);
      clip_sb.note_vertex(x, y, z, fin);
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic drain();
      while (clip_sb.expected_items.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 8) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
      endcase
   endfunction

   task automatic random_polygon();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
         send_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
   endtask

   task automatic random_plane();
      write_csr(REG_NORMAL_X, $urandom_range(2) == 0 ? $urandom : 32'($urandom_range(0, 4)) << 15);
      write_csr(REG_NORMAL_Y, $urandom_range(3) == 0 ? 32'h8000_0000 : $urandom);
      write_csr(REG_NORMAL_Z, $urandom_range(1) ? 32'h7fff_ffff : 32'h0001_0000);
      write_csr(REG_PLANE_D, $urandom_range(1) ? $urandom : 32'($urandom_range(0, 8)) << 16);
   endtask

   initial begin
      clip_sb = new();
      clip_sb.clear();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: default plane z <= 0.
      send_vertex(32'hffff_0000, 0, 32'hffff_0000, 1);           // single inside vertex
      send_vertex(0, 0, 32'h0001_0000, 1);                       // single outside: marker
      send_vertex(0, 0, 32'hffff_0000, 0);                       // crossing triangle
      send_vertex(32'h0001_0000, 0, 32'h0001_0000, 0);
      send_vertex(0, 32'h0001_0000, 32'hffff_0000, 1);
      send_vertex(0, 0, 32'h0002_0000, 0);                       // fully outside
      send_vertex(32'h0001_0000, 0, 32'h0003_0000, 1);
      send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0); // extremes
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
      send_vertex(0, 0, 0, 1);                                   // on the plane
      drain();
      // Saturating distances, unused register index.
      write_csr(REG_NORMAL_X, 32'h8000_0000);
      write_csr(REG_NORMAL_Y, 32'h8000_0000);
      write_csr(REG_NORMAL_Z, 32'h8000_0000);
      write_csr(REG_PLANE_D, 32'h7fff_ffff);
      write_csr(8'd7, 32'hffff_ffff);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      send_vertex(32'h8000_0000, 32'h7fff_ffff, 0, 1);
      drain();
      write_csr(REG_NORMAL_X, 32'h7fff_ffff);
      write_csr(REG_NORMAL_Y, 32'h7fff_ffff);
      write_csr(REG_NORMAL_Z, 32'h7fff_ffff);
      write_csr(REG_PLANE_D, 32'h8000_0000);
      send_vertex(32'h8000_0000, 0, 32'h7fff_ffff, 0);
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
      drain();

      // Long receiver hold-off while vertices keep coming.
      write_csr(REG_NORMAL_X, 0);
      write_csr(REG_NORMAL_Y, 0);
      write_csr(REG_NORMAL_Z, 32'h0001_0000);
      write_csr(REG_PLANE_D, 32'h0010_0000);
      fork
         begin
            recv_hold = 1;
            repeat (400) @(negedge clock);
            recv_hold = 0;
         end
         repeat (12) send_vertex(0, 0, 0, 0);
      join
      send_vertex(0, 0, 0, 1);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         random_plane();
         for (int k = 0; k < 24; k++) random_polygon();
         drain();
      end

      if (clip_sb.errors == 0 && clip_sb.expected_items.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

[filelist.f]
rtl/ppc_pkg.sv
rtl/ppc_fifo.sv
rtl/ppc_front.sv
rtl/ppc_back.sv
rtl/polygon_plane_clip_core.sv
sim/polygon_plane_clip_core_test.sv
